>>> rtl/buddy_block_allocator_defines.svh
// assertion macros for the buddy block allocator checker
// no dependencies
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator check failed");

// next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator check failed");

`endif

>>> rtl/bba_pkg.sv
// shared constants, types, flag-slot and reset-layout functions of the buddy block allocator
// no dependencies
package bba_pkg;

   localparam int LEVELS          = 8;
   localparam int MIN_BLOCK_BYTES = 64;
   localparam int BUFFER_BYTES    = 8192;
   localparam int RESERVED_UNITS  = 1;

   localparam int UNITS     = 1 << (LEVELS - 1);
   localparam int FLAGS     = UNITS - 1;
   localparam int UW        = LEVELS;
   localparam int AW        = LEVELS - 1;
   localparam int LW        = $clog2(LEVELS);
   localparam int KW        = $clog2(LEVELS + 1);
   localparam int MIN_SHIFT = $clog2(MIN_BLOCK_BYTES);

   localparam int OP_W     = 1;
   localparam int SIZE_W   = 14;
   localparam int OFF_W    = 13;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd2;

   typedef logic [UW-1:0] unit_type;
   typedef unit_type [LEVELS-1:0] head_vec_type;
   typedef logic [FLAGS-1:0] flag_vec_type;

   localparam unit_type NONE_U = unit_type'(UNITS);

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SIZE_W-1:0] size;
      logic [OFF_W-1:0]  offset;
   } item_type;

   typedef struct packed {
      logic [OFF_W-1:0]    offset;
      logic [STATUS_W-1:0] status;
   } result_type;

   typedef struct packed {
      logic          wr;
      logic [AW-1:0] addr;
      unit_type      data;
   } ram_cmd_type;

   function automatic logic [LEVELS-1:0] pair_slot(logic [LW-1:0] lvl, logic [AW-1:0] idx);
      pair_slot = (LEVELS'(1) << (lvl - LW'(1))) - LEVELS'(1) + LEVELS'(idx >> 1);
   endfunction

   function automatic logic [LEVELS-1:0] split_slot(logic [LW-1:0] lvl, logic [AW-1:0] idx);
      split_slot = (LEVELS'(1) << lvl) - LEVELS'(1) + LEVELS'(idx);
   endfunction

   function automatic head_vec_type reset_heads();
      head_vec_type h;
      int unsigned  b, s, e, sh;
      b = (RESERVED_UNITS < UNITS) ? RESERVED_UNITS : UNITS;
      for (int l = 0; l < LEVELS; l++) begin
         h[l] = NONE_U;
         sh   = LEVELS - 1 - l;
         s    = UNITS >> l;
         e    = ((b + s - 1) >> sh) << sh;
         if (e < UNITS && ((e >> sh) & 1) != 0) begin
            h[l] = unit_type'(e);
         end
      end
      return h;
   endfunction

   function automatic flag_vec_type reset_pairs();
      flag_vec_type p;
      int unsigned  b, s, e, sh, cnt, slot;
      p = '0;
      b = (RESERVED_UNITS < UNITS) ? RESERVED_UNITS : UNITS;
      for (int l = 1; l < LEVELS; l++) begin
         sh  = LEVELS - 1 - l;
         s   = UNITS >> l;
         e   = ((b + s - 1) >> sh) << sh;
         cnt = (e < UNITS) ? (e >> sh) : (1 << l);
         for (int unsigned i = 0; i < cnt; i++) begin
            slot = (1 << (l - 1)) - 1 + (i >> 1);
            if (slot < FLAGS) begin
               p[AW'(slot)] = ~p[AW'(slot)];
            end
         end
      end
      return p;
   endfunction

   function automatic flag_vec_type reset_splits();
      flag_vec_type f;
      int unsigned  b, s, sh, cnt, slot;
      f = '0;
      b = (RESERVED_UNITS < UNITS) ? RESERVED_UNITS : UNITS;
      for (int l = 0; l + 1 < LEVELS; l++) begin
         sh  = LEVELS - 1 - l;
         s   = UNITS >> l;
         cnt = (b + s - 1) >> sh;
         for (int unsigned i = 0; i < cnt; i++) begin
            slot = (1 << l) - 1 + i;
            if (slot < FLAGS) begin
               f[AW'(slot)] = 1'b1;
            end
         end
      end
      return f;
   endfunction

endpackage

>>> rtl/bba_link_ram.sv
// single-port link memory, one entry per minimum unit, registered read
// depends on bba_pkg
module bba_link_ram (
   input  logic                  clock,
   input  bba_pkg::ram_cmd_type  cmd,
   output bba_pkg::unit_type     rd_data
);

   bba_pkg::unit_type mem [bba_pkg::UNITS];
   bba_pkg::unit_type rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[cmd.addr] <= cmd.data;
      end
      rd_ff <= mem[cmd.addr];
   end

   assign rd_data = rd_ff;

endmodule

>>> rtl/bba_seq.sv
// allocate / free sequencer: list heads, pair and split flag memories, link memory accesses
// depends on bba_pkg; drives two bba_link_ram instances
module bba_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  bba_pkg::item_type     item,
   output logic                  res_valid,
   input  logic                  res_take,
   output bba_pkg::result_type   res,
   output bba_pkg::ram_cmd_type  next_cmd,
   output bba_pkg::ram_cmd_type  prev_cmd,
   input  bba_pkg::unit_type     next_rd,
   input  bba_pkg::unit_type     prev_rd
);

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_ALLOC  = 4'd2;
   localparam logic [3:0] S_FREE   = 4'd3;
   localparam logic [3:0] S_ALOOP  = 4'd4;
   localparam logic [3:0] S_APUSH1 = 4'd5;
   localparam logic [3:0] S_APUSH2 = 4'd6;
   localparam logic [3:0] S_MCHK   = 4'd7;
   localparam logic [3:0] S_MRM2   = 4'd8;
   localparam logic [3:0] S_MPUSH  = 4'd9;
   localparam logic [3:0] S_REM_RD = 4'd10;
   localparam logic [3:0] S_REM_WR = 4'd11;
   localparam logic [3:0] S_PSH_A  = 4'd12;
   localparam logic [3:0] S_PSH_B  = 4'd13;
   localparam logic [3:0] S_DONE   = 4'd14;
   localparam logic [3:0] S_FWALK  = 4'd15;

   localparam int LW       = bba_pkg::LW;
   localparam int AW       = bba_pkg::AW;
   localparam int UW       = bba_pkg::UW;
   localparam int LEVELS_W = bba_pkg::LEVELS;

   localparam logic [bba_pkg::UNITS-1:0] PAIR_INIT  = {1'b0, bba_pkg::reset_pairs()};
   localparam logic [bba_pkg::UNITS-1:0] SPLIT_INIT = {1'b0, bba_pkg::reset_splits()};

   logic [3:0]                    state_ff, state_in, ret_ff, ret_in;
   logic [AW-1:0]                 init_cnt_ff, init_cnt_in;
   bba_pkg::item_type             item_ff, item_in;
   logic [LW-1:0]                 j_ff, j_in, lvl_ff, lvl_in, pl_ff, pl_in;
   logic [LW-1:0]                 arg_lvl_ff, arg_lvl_in, fl_ff, fl_in;
   bba_pkg::unit_type             u_ff, u_in, arg_u_ff, arg_u_in, hsave_ff, hsave_in;
   logic [AW-1:0]                 pi_ff, pi_in;
   logic [bba_pkg::OFF_W-1:0]     res_off_ff, res_off_in;
   logic [bba_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   bba_pkg::head_vec_type         head_ff, head_in;
   logic                          tgl_pend_ff, tgl_pend_in;
   logic [AW-1:0]                 tgl_slot_ff, tgl_slot_in;

   logic                          pair_mem [bba_pkg::UNITS];
   logic                          split_mem [bba_pkg::UNITS];
   logic                          pair_rd_ff, split_rd_ff;
   logic [AW-1:0]                 pair_addr, split_addr;
   logic                          pair_we, pair_wd, split_we, split_wd;

   logic                          pair_tgl, split_wr, split_val;
   logic [LEVELS_W-1:0]           pair_ts, split_ws;

   logic [bba_pkg::KW-1:0]        a_k;
   logic [LW-1:0]                 a_lvl, a_j;
   logic                          a_err;
   logic [31:0]                   f_off32;
   logic                          f_bad;
   bba_pkg::unit_type             f_u;
   logic [AW-1:0]                 fw_idx, fr_idx;
   logic                          fw_aligned, fw_split;
   logic [LEVELS_W-1:0]           fw_ss, fr_ss, m_ps;
   bba_pkg::unit_type             hj, hl;
   logic [AW-1:0]                 hj_idx, hl_idx;

   // size class and source level for allocate
   always_comb begin
      a_k = bba_pkg::KW'(bba_pkg::LEVELS);
      for (int kk = bba_pkg::LEVELS - 1; kk >= 0; kk--) begin
         if ((64'(bba_pkg::MIN_BLOCK_BYTES) << kk) >= 64'(item_ff.size)) begin
            a_k = bba_pkg::KW'(kk);
         end
      end
      a_err = a_k > bba_pkg::KW'(bba_pkg::LEVELS - 2);
      a_lvl = LW'(bba_pkg::LEVELS - 1 - int'(a_k));
      a_j   = '0;
      for (int jj = 1; jj < bba_pkg::LEVELS; jj++) begin
         if (LW'(jj) <= a_lvl && head_ff[jj] < bba_pkg::NONE_U) begin
            a_j = LW'(jj);
         end
      end
   end

   // offset check of the block to free
   always_comb begin
      f_off32 = 32'(item_ff.offset);
      f_bad   = f_off32 >= 32'(bba_pkg::BUFFER_BYTES)
             || (f_off32 & 32'(bba_pkg::MIN_BLOCK_BYTES - 1)) != 32'd0
             || (f_off32 >> bba_pkg::MIN_SHIFT) >= 32'(bba_pkg::UNITS)
             || (f_off32 >> bba_pkg::MIN_SHIFT) < 32'(bba_pkg::RESERVED_UNITS);
      f_u     = UW'(f_off32 >> bba_pkg::MIN_SHIFT);
   end

   // level walk of the block to free, one level a cycle
   assign fw_idx     = AW'(f_u >> (LW'(bba_pkg::LEVELS - 1) - fl_ff));
   assign fw_aligned = (fw_idx << (LW'(bba_pkg::LEVELS - 1) - fl_ff)) == f_u[AW-1:0];
   assign fw_ss      = bba_pkg::split_slot(fl_ff, fw_idx);
   assign fw_split   = fw_ss < LEVELS_W'(bba_pkg::FLAGS) && split_rd_ff;
   assign fr_idx     = AW'(f_u >> (LW'(bba_pkg::LEVELS - 1) - fl_in));
   assign fr_ss      = bba_pkg::split_slot(fl_in, fr_idx);

   assign hj     = head_ff[j_ff];
   assign hl     = head_ff[lvl_ff];
   assign hj_idx = AW'(hj >> (LW'(bba_pkg::LEVELS - 1) - j_ff));
   assign hl_idx = AW'(hl >> (LW'(bba_pkg::LEVELS - 1) - lvl_ff));
   assign m_ps   = bba_pkg::pair_slot(pl_ff + LW'(1), AW'(pi_ff << 1));

   assign item_ready = state_ff == S_IDLE;
   assign res_valid  = state_ff == S_DONE;
   assign res        = '{offset: res_off_ff, status: res_status_ff};

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      init_cnt_in   = init_cnt_ff;
      item_in       = item_ff;
      j_in          = j_ff;
      lvl_in        = lvl_ff;
      pl_in         = pl_ff;
      pi_in         = pi_ff;
      fl_in         = fl_ff;
      arg_lvl_in    = arg_lvl_ff;
      u_in          = u_ff;
      arg_u_in      = arg_u_ff;
      hsave_in      = hsave_ff;
      res_off_in    = res_off_ff;
      res_status_in = res_status_ff;
      head_in       = head_ff;
      pair_tgl      = 1'b0;
      pair_ts       = '0;
      split_wr      = 1'b0;
      split_ws      = '0;
      split_val     = 1'b0;
      next_cmd      = '{wr: 1'b0, addr: arg_u_ff[AW-1:0], data: '0};
      prev_cmd      = '{wr: 1'b0, addr: arg_u_ff[AW-1:0], data: '0};

      case (state_ff)
         S_INIT: begin
            next_cmd    = '{wr: 1'b1, addr: init_cnt_ff, data: bba_pkg::NONE_U};
            prev_cmd    = '{wr: 1'b1, addr: init_cnt_ff, data: bba_pkg::NONE_U};
            init_cnt_in = init_cnt_ff + AW'(1);
            if (&init_cnt_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               item_in       = item;
               res_off_in    = '0;
               res_status_in = bba_pkg::STATUS_OK;
               state_in      = (item.op == bba_pkg::OP_FREE) ? S_FREE : S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (a_err) begin
               res_status_in = bba_pkg::STATUS_BAD;
               state_in      = S_DONE;
            end else if (a_j == '0) begin
               res_status_in = bba_pkg::STATUS_NO_SPACE;
               state_in      = S_DONE;
            end else begin
               j_in     = a_j;
               lvl_in   = a_lvl;
               state_in = S_ALOOP;
            end
         end
         S_ALOOP: begin
            if (j_ff < lvl_ff) begin
               u_in       = hj;
               pair_tgl   = 1'b1;
               pair_ts    = bba_pkg::pair_slot(j_ff, hj_idx);
               split_wr   = 1'b1;
               split_ws   = bba_pkg::split_slot(j_ff, hj_idx);
               split_val  = 1'b1;
               arg_lvl_in = j_ff;
               arg_u_in   = hj;
               ret_in     = S_APUSH1;
               state_in   = S_REM_RD;
            end else if (hl >= bba_pkg::NONE_U) begin
               res_status_in = bba_pkg::STATUS_NO_SPACE;
               state_in      = S_DONE;
            end else begin
               pair_tgl   = 1'b1;
               pair_ts    = bba_pkg::pair_slot(lvl_ff, hl_idx);
               res_off_in = bba_pkg::OFF_W'(32'(hl) << bba_pkg::MIN_SHIFT);
               arg_lvl_in = lvl_ff;
               arg_u_in   = hl;
               ret_in     = S_DONE;
               state_in   = S_REM_RD;
            end
         end
         S_APUSH1: begin
            arg_lvl_in = j_ff + LW'(1);
            arg_u_in   = u_ff;
            ret_in     = S_APUSH2;
            state_in   = S_PSH_A;
         end
         S_APUSH2: begin
            arg_lvl_in = j_ff + LW'(1);
            arg_u_in   = u_ff + (bba_pkg::NONE_U >> (j_ff + LW'(1)));
            j_in       = j_ff + LW'(1);
            ret_in     = S_ALOOP;
            state_in   = S_PSH_A;
         end
         S_FREE: begin
            if (f_bad) begin
               res_status_in = bba_pkg::STATUS_BAD;
               state_in      = S_DONE;
            end else begin
               fl_in    = LW'(1);
               state_in = S_FWALK;
            end
         end
         S_FWALK: begin
            if (fl_ff == LW'(bba_pkg::LEVELS - 1) || (fw_aligned && !fw_split)) begin
               pair_tgl   = 1'b1;
               pair_ts    = bba_pkg::pair_slot(fl_ff, fw_idx);
               arg_lvl_in = fl_ff;
               arg_u_in   = f_u;
               pl_in      = fl_ff - LW'(1);
               pi_in      = fw_idx >> 1;
               ret_in     = S_MCHK;
               state_in   = S_PSH_A;
            end else begin
               fl_in = fl_ff + LW'(1);
            end
         end
         S_MCHK: begin
            if (pl_ff != '0 && !(m_ps < LEVELS_W'(bba_pkg::FLAGS) && pair_rd_ff)) begin
               arg_lvl_in = pl_ff + LW'(1);
               arg_u_in   = UW'(pi_ff) << (LW'(bba_pkg::LEVELS - 1) - pl_ff);
               ret_in     = S_MRM2;
               state_in   = S_REM_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MRM2: begin
            arg_lvl_in = pl_ff + LW'(1);
            arg_u_in   = UW'({pi_ff, 1'b1}) << (LW'(bba_pkg::LEVELS - 2) - pl_ff);
            ret_in     = S_MPUSH;
            state_in   = S_REM_RD;
         end
         S_MPUSH: begin
            split_wr   = 1'b1;
            split_ws   = bba_pkg::split_slot(pl_ff, pi_ff);
            split_val  = 1'b0;
            pair_tgl   = 1'b1;
            pair_ts    = bba_pkg::pair_slot(pl_ff, pi_ff);
            arg_lvl_in = pl_ff;
            arg_u_in   = UW'(pi_ff) << (LW'(bba_pkg::LEVELS - 1) - pl_ff);
            pl_in      = pl_ff - LW'(1);
            pi_in      = pi_ff >> 1;
            ret_in     = S_MCHK;
            state_in   = S_PSH_A;
         end
         S_REM_RD: begin
            state_in = S_REM_WR;
         end
         S_REM_WR: begin
            if (head_ff[arg_lvl_ff] == arg_u_ff) begin
               head_in[arg_lvl_ff] = next_rd;
            end
            if (next_rd < bba_pkg::NONE_U) begin
               prev_cmd = '{wr: 1'b1, addr: next_rd[AW-1:0], data: prev_rd};
            end
            if (prev_rd < bba_pkg::NONE_U) begin
               next_cmd = '{wr: 1'b1, addr: prev_rd[AW-1:0], data: next_rd};
            end
            state_in = ret_ff;
         end
         S_PSH_A: begin
            next_cmd            = '{wr: 1'b1, addr: arg_u_ff[AW-1:0], data: head_ff[arg_lvl_ff]};
            prev_cmd            = '{wr: 1'b1, addr: arg_u_ff[AW-1:0], data: bba_pkg::NONE_U};
            hsave_in            = head_ff[arg_lvl_ff];
            head_in[arg_lvl_ff] = arg_u_ff;
            state_in            = S_PSH_B;
         end
         S_PSH_B: begin
            if (hsave_ff < bba_pkg::NONE_U) begin
               prev_cmd = '{wr: 1'b1, addr: hsave_ff[AW-1:0], data: arg_u_ff};
            end
            state_in = ret_ff;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // pair toggle: read in the cycle of the request, written back in the next
   assign tgl_pend_in = pair_tgl && pair_ts < LEVELS_W'(bba_pkg::FLAGS);
   assign tgl_slot_in = pair_ts[AW-1:0];

   always_comb begin
      pair_addr  = m_ps[AW-1:0];
      pair_we    = 1'b0;
      pair_wd    = 1'b0;
      split_addr = fr_ss[AW-1:0];
      split_we   = 1'b0;
      split_wd   = 1'b0;
      if (state_ff == S_INIT) begin
         pair_addr  = init_cnt_ff;
         pair_we    = 1'b1;
         pair_wd    = PAIR_INIT[init_cnt_ff];
         split_addr = init_cnt_ff;
         split_we   = 1'b1;
         split_wd   = SPLIT_INIT[init_cnt_ff];
      end else begin
         if (tgl_pend_ff) begin
            pair_addr = tgl_slot_ff;
            pair_we   = 1'b1;
            pair_wd   = ~pair_rd_ff;
         end else if (pair_tgl) begin
            pair_addr = pair_ts[AW-1:0];
         end
         if (split_wr && split_ws < LEVELS_W'(bba_pkg::FLAGS)) begin
            split_addr = split_ws[AW-1:0];
            split_we   = 1'b1;
            split_wd   = split_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pair_we) begin
         pair_mem[pair_addr] <= pair_wd;
      end
      pair_rd_ff <= pair_mem[pair_addr];
      if (split_we) begin
         split_mem[split_addr] <= split_wd;
      end
      split_rd_ff <= split_mem[split_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         init_cnt_ff <= '0;
         head_ff     <= bba_pkg::reset_heads();
         tgl_pend_ff <= 1'b0;
         ret_ff      <= S_IDLE;
      end else begin
         state_ff    <= state_in;
         init_cnt_ff <= init_cnt_in;
         head_ff     <= head_in;
         tgl_pend_ff <= tgl_pend_in;
         ret_ff      <= ret_in;
      end
      tgl_slot_ff   <= tgl_slot_in;
      item_ff       <= item_in;
      j_ff          <= j_in;
      lvl_ff        <= lvl_in;
      pl_ff         <= pl_in;
      pi_ff         <= pi_in;
      fl_ff         <= fl_in;
      arg_lvl_ff    <= arg_lvl_in;
      u_ff          <= u_in;
      arg_u_ff      <= arg_u_in;
      hsave_ff      <= hsave_in;
      res_off_ff    <= res_off_in;
      res_status_ff <= res_status_in;
   end

endmodule

>>> rtl/buddy_block_allocator.sv
// buddy block allocator top level: request/response handshake and result register
// depends on bba_pkg, bba_seq and bba_link_ram
//
// request channel (req_*): operation 0 allocates req_request_size bytes, 1 frees the
// block at req_free_offset. one request is taken at a time; req_ready is high only
// while the sequencer is idle.
// response channel (rsp_*): one response per request, rsp_block_offset and rsp_status
// (0 ok, 1 no free block, 2 too large or bad offset). the response sits in an output
// register, so the next request is taken while it waits for rsp_ready.
// an allocate splits a larger block level by level down to the size asked for; a free
// searches the levels for the block, then merges it with its buddy level by level; each step is
// bounded by the single-port link and flag memories (read, then write back).
// reset: list heads take the reserved-region layout at once; then a clearing pass over
// every minimum unit writes the link memories and loads the pair and split flag memories,
// and no request is taken until it ends.
// a stalled receiver holds the response; the sequencer waits with its next result
// until the output register is free.
module buddy_block_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bba_pkg::OP_W-1:0]        req_operation,
   input  logic [bba_pkg::SIZE_W-1:0]      req_request_size,
   input  logic [bba_pkg::OFF_W-1:0]       req_free_offset,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bba_pkg::OFF_W-1:0]       rsp_block_offset,
   output logic [bba_pkg::STATUS_W-1:0]    rsp_status
);

   bba_pkg::item_type     item;
   bba_pkg::result_type   res;
   bba_pkg::ram_cmd_type  next_cmd, prev_cmd;
   bba_pkg::unit_type     next_rd, prev_rd;
   logic                  res_valid, res_take;
   logic                  rsp_valid_ff, rsp_valid_in;
   bba_pkg::result_type   rsp_ff, rsp_in;

   assign item = '{op: req_operation, size: req_request_size, offset: req_free_offset};

   bba_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid),
      .item_ready (req_ready),
      .item       (item),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res),
      .next_cmd   (next_cmd),
      .prev_cmd   (prev_cmd),
      .next_rd    (next_rd),
      .prev_rd    (prev_rd)
   );

   bba_link_ram u_next_ram (
      .clock   (clock),
      .cmd     (next_cmd),
      .rd_data (next_rd)
   );

   bba_link_ram u_prev_ram (
      .clock   (clock),
      .cmd     (prev_cmd),
      .rd_data (prev_rd)
   );

   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_offset = rsp_ff.offset;
   assign rsp_status       = rsp_ff.status;

endmodule

>>> rtl/bba_checker.sv
// port-level checks of the buddy block allocator, bound to the top level
// depends on bba_pkg and buddy_block_allocator_defines.svh
`include "buddy_block_allocator_defines.svh"

module bba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bba_pkg::OFF_W-1:0]     rsp_block_offset,
   input logic [bba_pkg::STATUS_W-1:0]  rsp_status
);

   `BBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_block_offset) && $stable(rsp_status))
   `BBA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == bba_pkg::STATUS_OK || rsp_status == bba_pkg::STATUS_NO_SPACE || rsp_status == bba_pkg::STATUS_BAD)
   `BBA_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_status != bba_pkg::STATUS_OK, rsp_block_offset == '0)
   `BBA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_block_offset (rsp_block_offset),
   .rsp_status       (rsp_status)
);
